/* src/klbs_pkg.sv */
package klbs_pkg;

    localparam int unsigned PROG_SLOTS_DEF         = 16;
    localparam int unsigned BATTERY_HOLD_TICKS_DEF = 100;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned HOLD_W     = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROGRAM_COUNT     = 3'd0,
        REG_START_PROGRAM     = 3'd1,
        REG_BATTERY_THRESHOLD = 3'd2,
        REG_SHORT_PRESS_LIMIT = 3'd3,
        REG_LONG_PRESS_LIMIT  = 3'd4,
        REG_BLINK_ON_TIME     = 3'd5,
        REG_BLINK_OFF_TIME    = 3'd6,
        REG_PAUSE_TIME        = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_BATTERY = 2'd1,
        CAUSE_KEY     = 2'd2
    } t_cause;

    // register reset values
    localparam logic [4:0]  PROGRAM_COUNT_RST     = 5'd1;
    localparam logic [3:0]  START_PROGRAM_RST     = 4'd0;
    localparam logic [9:0]  BATTERY_THRESHOLD_RST = 10'd512;
    localparam logic [15:0] SHORT_PRESS_RST       = 16'd800;
    localparam logic [15:0] LONG_PRESS_RST        = 16'd5000;
    localparam logic [15:0] BLINK_ON_RST          = 16'd100;
    localparam logic [15:0] BLINK_OFF_RST         = 16'd300;
    localparam logic [15:0] PAUSE_RST             = 16'd1000;

    typedef struct packed {
        logic [4:0]  program_count;
        logic [9:0]  battery_threshold;
        logic [15:0] short_press_limit;
        logic [15:0] long_press_limit;
        logic [15:0] blink_on_time;
        logic [15:0] blink_off_time;
        logic [15:0] pause_time;
    } t_cfg;

    typedef struct packed {
        logic       led_on;
        logic [3:0] program_index;
        logic       program_changed;
        logic       shutdown;
        t_cause     shutdown_cause;
    } t_result;

endpackage

/* src/key_led_battery_supervisor_top.sv */
// Key, LED and battery supervisor, stepped once per millisecond tick.
// Input channel (i_valid / o_ready): one transaction per tick with the sampled
// key level and a 10-bit battery reading. Output channel (o_valid / i_ready):
// exactly one result per input, holding LED level, program index, a
// program-changed pulse and the latched shutdown request with its cause.
// The result of an accepted transaction is registered in the output register and
// is offered on the output channel in the next cycle.
// Throughput is one transaction per cycle without stalls, set by the single result register;
// all timer and rule updates finish in one combinational pass after the state registers.
// When the receiver stalls the result stays in the output register and
// o_ready drops, so no further tick is taken until that result is accepted.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// write at an edge with the block idle, which the block does not enforce. Writing
// start_program also presets the program. Synchronous active-low reset loads the
// register defaults, clears timers, lights the LED, selects the start program and
// clears shutdown. Once shutdown latches, steps change no state until reset.
module key_led_battery_supervisor_top #(
    parameter int unsigned PROG_SLOTS_P       = klbs_pkg::PROG_SLOTS_DEF,
    parameter int unsigned BATTERY_HOLD_TICKS = klbs_pkg::BATTERY_HOLD_TICKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [klbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [klbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_key_down,
    input  logic [9:0]                      i_battery_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_led_on,
    output logic [3:0]                      o_program_index,
    output logic                            o_program_changed,
    output logic                            o_shutdown,
    output logic [1:0]                      o_shutdown_cause
);
    import klbs_pkg::*;

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;
    t_cause  off_latched;
    logic    in_fire;

    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.program_count     <= PROGRAM_COUNT_RST;
            r_cfg.battery_threshold <= BATTERY_THRESHOLD_RST;
            r_cfg.short_press_limit <= SHORT_PRESS_RST;
            r_cfg.long_press_limit  <= LONG_PRESS_RST;
            r_cfg.blink_on_time     <= BLINK_ON_RST;
            r_cfg.blink_off_time    <= BLINK_OFF_RST;
            r_cfg.pause_time        <= PAUSE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_PROGRAM_COUNT:     r_cfg.program_count     <= i_cfg_data[4:0];
                REG_START_PROGRAM:     ; // preset only, handled in the core
                REG_BATTERY_THRESHOLD: r_cfg.battery_threshold <= i_cfg_data[9:0];
                REG_SHORT_PRESS_LIMIT: r_cfg.short_press_limit <= i_cfg_data;
                REG_LONG_PRESS_LIMIT:  r_cfg.long_press_limit  <= i_cfg_data;
                REG_BLINK_ON_TIME:     r_cfg.blink_on_time     <= i_cfg_data;
                REG_BLINK_OFF_TIME:    r_cfg.blink_off_time    <= i_cfg_data;
                REG_PAUSE_TIME:        r_cfg.pause_time        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    klbs_core #(
        .PROG_SLOTS_P       (PROG_SLOTS_P),
        .BATTERY_HOLD_TICKS (BATTERY_HOLD_TICKS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_preset_we      (i_cfg_we && t_cfg_reg'(i_cfg_idx) == REG_START_PROGRAM),
        .i_preset_val     (i_cfg_data[3:0]),
        .i_step           (in_fire),
        .i_key_down       (i_key_down),
        .i_battery_sample (i_battery_sample),
        .o_result         (step_result),
        .o_off_latched    (off_latched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= step_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_led_on          = r_out.led_on;
    assign o_program_index   = r_out.program_index;
    assign o_program_changed = r_out.program_changed;
    assign o_shutdown        = r_out.shutdown;
    assign o_shutdown_cause  = r_out.shutdown_cause;

    // shutdown cause never changes once latched
    a_off_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (off_latched != CAUSE_NONE) |=> (off_latched == $past(off_latched)))
        else $error("latched shutdown cause changed");

    a_dark_on_shutdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_shutdown) |-> (!o_led_on && !o_program_changed))
        else $error("led lit or program change reported during shutdown");

    a_cause_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_shutdown == (o_shutdown_cause != CAUSE_NONE)))
        else $error("shutdown flag and cause disagree");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_ready)
        else $error("input taken while result stalled");

endmodule

/* src/klbs_core.sv */
module klbs_core #(
    parameter int unsigned PROG_SLOTS_P       = klbs_pkg::PROG_SLOTS_DEF,
    parameter int unsigned BATTERY_HOLD_TICKS = klbs_pkg::BATTERY_HOLD_TICKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  klbs_pkg::t_cfg    i_cfg,
    input  logic              i_preset_we,
    input  logic [3:0]        i_preset_val,
    input  logic              i_step,
    input  logic              i_key_down,
    input  logic [9:0]        i_battery_sample,
    output klbs_pkg::t_result o_result,
    output klbs_pkg::t_cause  o_off_latched
);
    import klbs_pkg::*;

    localparam int unsigned PROG_LIM = (PROG_SLOTS_P < 16) ?
                                       ((PROG_SLOTS_P < 1) ? 1 : PROG_SLOTS_P) : 16;
    localparam logic [4:0]        PROG_LIM_V = 5'(PROG_LIM);
    localparam logic [HOLD_W-1:0] HOLD_V     = HOLD_W'(BATTERY_HOLD_TICKS);

    logic [15:0]       r_key_timer,   n_key_timer;
    logic              r_key_held,    n_key_held;
    logic [15:0]       r_blink_timer, n_blink_timer;
    logic [4:0]        r_blinks_left, n_blinks_left;
    logic              r_led_level,   n_led_level;
    logic [HOLD_W-1:0] r_batt_hold,   n_batt_hold;
    logic [3:0]        r_program,     n_program;
    t_cause            r_off,         n_off;
    logic              changed;
    logic [4:0]        eff_count;

    always_comb begin
        priority if (i_cfg.program_count == 5'd0) begin
            eff_count = 5'd1;
        end else if (i_cfg.program_count > PROG_LIM_V) begin
            eff_count = PROG_LIM_V;
        end else begin
            eff_count = i_cfg.program_count;
        end
    end

    always_comb begin
        logic [4:0] next_prog;
        n_key_timer   = r_key_timer;
        n_key_held    = r_key_held;
        n_blink_timer = r_blink_timer;
        n_blinks_left = r_blinks_left;
        n_led_level   = r_led_level;
        n_batt_hold   = r_batt_hold;
        n_program     = r_program;
        n_off         = r_off;
        changed       = 1'b0;
        next_prog     = 5'd0;

        if (r_off == CAUSE_NONE) begin
            if ({1'b0, r_program} >= eff_count) begin
                n_program = 4'd0;
            end
            if (r_key_timer != 16'hFFFF) begin
                n_key_timer = r_key_timer + 16'd1;
            end
            if (r_blink_timer != 16'd0) begin
                n_blink_timer = r_blink_timer - 16'd1;
            end
            if (r_batt_hold != '0) begin
                n_batt_hold = r_batt_hold - HOLD_W'(1);
            end

            // battery rule
            if (i_battery_sample > i_cfg.battery_threshold) begin
                n_batt_hold = HOLD_V;
            end
            if (n_batt_hold == '0) begin
                n_off = CAUSE_BATTERY;
            end

            // key rule
            if (n_off == CAUSE_NONE) begin
                if (r_key_held) begin
                    if (!i_key_down) begin
                        if (n_key_timer != 16'd0 &&
                            n_key_timer <= i_cfg.short_press_limit) begin
                            next_prog = {1'b0, n_program} + 5'd1;
                            n_program = (next_prog >= eff_count) ? 4'd0 : next_prog[3:0];
                            n_led_level   = 1'b0;
                            n_blinks_left = 5'd0;
                            changed       = 1'b1;
                        end
                        n_key_held = 1'b0;
                    end else if (n_key_timer > i_cfg.short_press_limit &&
                                 n_key_timer <= i_cfg.long_press_limit) begin
                        n_off = CAUSE_KEY;
                    end
                end else if (i_key_down) begin
                    n_key_timer = 16'd0;
                    n_key_held  = 1'b1;
                end
            end

            // blink sequencer
            if (n_off == CAUSE_NONE && n_blink_timer == 16'd0) begin
                if (n_blinks_left == 5'd0) begin
                    n_blinks_left = {1'b0, n_program} + 5'd1;
                    n_blink_timer = i_cfg.pause_time;
                end else if (!n_led_level) begin
                    n_led_level   = 1'b1;
                    n_blink_timer = i_cfg.blink_on_time;
                end else begin
                    n_led_level   = 1'b0;
                    n_blink_timer = i_cfg.blink_off_time;
                    n_blinks_left = n_blinks_left - 5'd1;
                end
            end
        end

        o_result.led_on          = (n_off == CAUSE_NONE) ? n_led_level : 1'b0;
        o_result.program_index   = n_program;
        o_result.program_changed = changed;
        o_result.shutdown        = (n_off != CAUSE_NONE);
        o_result.shutdown_cause  = n_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_timer   <= 16'd0;
            r_key_held    <= 1'b0;
            r_blink_timer <= 16'd0;
            r_blinks_left <= 5'd0;
            r_led_level   <= 1'b1;
            r_batt_hold   <= '0;
            r_program     <= START_PROGRAM_RST;
            r_off         <= CAUSE_NONE;
        end else if (i_preset_we) begin
            r_program <= i_preset_val;
        end else if (i_step) begin
            r_key_timer   <= n_key_timer;
            r_key_held    <= n_key_held;
            r_blink_timer <= n_blink_timer;
            r_blinks_left <= n_blinks_left;
            r_led_level   <= n_led_level;
            r_batt_hold   <= n_batt_hold;
            r_program     <= n_program;
            r_off         <= n_off;
        end
    end

    assign o_off_latched = r_off;

endmodule
